/* sv/dcd_pkg.sv */
// Shared types and constants for the directed cycle detector.
// Holds the sequencer state type, request codes and fixed field widths.
// No dependencies; the core and the testbench refer to it by scope.
`default_nettype none

package dcd_pkg;

    // Fixed widths of the payload and configuration fields.
    localparam int VERTEX_W = 6;
    localparam int COUNT_W  = 7;

    // Reset value of the vertex count register.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    // Request codes carried by req_type.
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_ROOT,
        ST_SCAN,
        ST_POP,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

/* sv/dcd_adj_store.sv */
// Adjacency store: one bit row per origin vertex, with a valid bit per row.
// A row that was never written reads as all zero, so reset clears the graph at once.
// Depends on no package; instantiated by directed_cycle_detect_core.
`default_nettype none

module dcd_adj_store #(
    parameter int Depth = 64
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_rd_en,
    input  wire                      i_wr_en,
    input  wire  [$clog2(Depth)-1:0] i_addr,
    input  wire  [Depth-1:0]         i_wr_row,
    output logic [Depth-1:0]         o_rd_row
);

    logic [Depth-1:0] r_mem [Depth];
    logic [Depth-1:0] r_row_vld;
    logic [Depth-1:0] r_rd_data;
    logic             r_rd_vld;

    // Row valid bits are control state and clear on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_vld[i_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_row_vld[i_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_row = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

/* sv/dcd_stack_store.sv */
// Search stack memory: holds the suspended frames of the depth-first search.
// Single address port, written on a push and read with registered data for a pop.
// Depends on no package; instantiated by directed_cycle_detect_core.
`default_nettype none

module dcd_stack_store #(
    parameter int Depth = 64,
    parameter int Width = 13
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(Depth)-1:0] i_addr,
    input  wire  [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/directed_cycle_detect_core.sv */
// Directed cycle detector: an add beat is accepted, then a row read-modify-write follows;
// an add with an endpoint out of range ends at its accept. A check beat walks the graph one
// neighbor test per cycle, through root steps, scan steps for each visited vertex and a pop
// step for each non-root vertex. The result beat is registered once the search ends and
// the output side is free; one add or check is in flight at a time.
// Reset is synchronous; the graph clears at once through per-row valid bits, with no clearing pass.
`default_nettype none

module directed_cycle_detect_core #(
    parameter int MaxVertices = 64
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Configuration: vertex count register.
    input  wire                              i_cfg_we,
    input  wire  [dcd_pkg::COUNT_W-1:0]      i_cfg_data,
    // Request channel.
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire                              i_req_type,
    input  wire  [dcd_pkg::VERTEX_W-1:0]     i_src_vertex,
    input  wire  [dcd_pkg::VERTEX_W-1:0]     i_dst_vertex,
    // Result channel.
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic                             o_has_cycle
);

    // Vertex index width, and a count width wide enough for the vertex count
    // register and for MaxVertices itself.
    localparam int VW = $clog2(MaxVertices);
    localparam int NW = ($clog2(MaxVertices + 1) > dcd_pkg::COUNT_W) ?
                        $clog2(MaxVertices + 1) : dcd_pkg::COUNT_W;
    localparam int SW = VW + NW;

    dcd_pkg::t_state r_state, n_state;

    logic [dcd_pkg::COUNT_W-1:0] r_vertex_count;
    logic [NW-1:0]               act_count;
    logic [NW-1:0]               r_root;
    logic [NW-1:0]               r_w;
    logic [VW-1:0]               r_u;
    logic [VW-1:0]               r_src;
    logic [VW-1:0]               r_dst;
    logic [VW:0]                 r_depth;
    logic [MaxVertices-1:0]      r_visited;
    logic [MaxVertices-1:0]      r_onpath;
    logic                        r_result;
    logic                        r_out_valid;
    logic                        r_has_cycle;

    logic [NW-1:0]          src_ext;
    logic [NW-1:0]          dst_ext;
    logic                   in_acc;
    logic                   add_ok;
    logic                   out_free;
    logic [VW-1:0]          root_idx;
    logic [VW-1:0]          w_idx;
    logic                   root_in;
    logic                   w_in;
    logic                   edge_bit;
    logic                   push_go;
    logic                   cyc_hit;
    logic                   pop_go;
    logic [VW:0]            depth_m1;
    logic [VW:0]            depth_m2;

    logic                   adj_rd_en;
    logic                   adj_wr_en;
    logic [VW-1:0]          adj_addr;
    logic [MaxVertices-1:0] adj_wr_row;
    logic [MaxVertices-1:0] adj_rd_row;

    logic                   stk_we;
    logic [VW-1:0]          stk_addr;
    logic [SW-1:0]          stk_wdata;
    logic [SW-1:0]          stk_rdata;
    logic [VW-1:0]          stk_vertex;
    logic [NW-1:0]          stk_next;

    // The active vertex count is the register capped at the store size.
    always_comb begin
        if (NW'(r_vertex_count) > NW'(MaxVertices)) begin
            act_count = NW'(MaxVertices);
        end else begin
            act_count = NW'(r_vertex_count);
        end
    end

    assign in_acc   = i_in_valid && !o_in_stall;
    assign src_ext  = NW'(i_src_vertex);
    assign dst_ext  = NW'(i_dst_vertex);
    // Edges with an endpoint outside the active vertex range are dropped.
    assign add_ok   = (src_ext < act_count) && (dst_ext < act_count);
    assign out_free = !r_out_valid || !i_out_stall;

    assign root_idx = r_root[VW-1:0];
    assign w_idx    = r_w[VW-1:0];
    assign root_in  = r_root < act_count;
    assign w_in     = r_w < act_count;
    assign edge_bit = adj_rd_row[w_idx];
    assign depth_m1 = r_depth - 1'b1;
    assign depth_m2 = r_depth - 2'd2;

    // The scan step: test one candidate neighbor of the top vertex per cycle.
    // An edge to a vertex on the current path is a back edge, which closes a cycle
    // (a self-loop included). An edge to an unvisited vertex descends into it.
    // Running past the last vertex finishes the top vertex and pops it.
    assign cyc_hit = (r_state == dcd_pkg::ST_SCAN) && w_in && edge_bit && r_onpath[w_idx];
    assign push_go = (r_state == dcd_pkg::ST_SCAN) && w_in && edge_bit &&
                     !r_onpath[w_idx] && !r_visited[w_idx];
    assign pop_go  = (r_state == dcd_pkg::ST_SCAN) && !w_in;

    assign stk_vertex = stk_rdata[SW-1:NW];
    assign stk_next   = stk_rdata[NW-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dcd_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_req_type == dcd_pkg::REQ_CHECK) begin
                        n_state = dcd_pkg::ST_ROOT;
                    end else if (add_ok) begin
                        n_state = dcd_pkg::ST_ADD;
                    end
                end
            end
            dcd_pkg::ST_ADD: begin
                n_state = dcd_pkg::ST_IDLE;
            end
            dcd_pkg::ST_ROOT: begin
                if (!root_in) begin
                    n_state = dcd_pkg::ST_DONE;
                end else if (!r_visited[root_idx]) begin
                    n_state = dcd_pkg::ST_SCAN;
                end
            end
            dcd_pkg::ST_SCAN: begin
                if (cyc_hit) begin
                    n_state = dcd_pkg::ST_DONE;
                end else if (pop_go) begin
                    if (r_depth == (VW+1)'(1)) begin
                        n_state = dcd_pkg::ST_ROOT;
                    end else begin
                        n_state = dcd_pkg::ST_POP;
                    end
                end
            end
            dcd_pkg::ST_POP: begin
                n_state = dcd_pkg::ST_SCAN;
            end
            dcd_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = dcd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dcd_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory controls for the current state.
    always_comb begin
        adj_rd_en  = 1'b0;
        adj_wr_en  = 1'b0;
        adj_addr   = '0;
        adj_wr_row = '0;
        stk_we     = 1'b0;
        stk_addr   = '0;
        stk_wdata  = '0;
        case (r_state)
            dcd_pkg::ST_IDLE: begin
                // Fetch the origin row for the read-modify-write of an add.
                if (in_acc && (i_req_type == dcd_pkg::REQ_ADD) && add_ok) begin
                    adj_rd_en = 1'b1;
                    adj_addr  = src_ext[VW-1:0];
                end
            end
            dcd_pkg::ST_ADD: begin
                adj_wr_en  = 1'b1;
                adj_addr   = r_src;
                adj_wr_row = adj_rd_row | (MaxVertices'(1) << r_dst);
            end
            dcd_pkg::ST_ROOT: begin
                if (root_in && !r_visited[root_idx]) begin
                    adj_rd_en = 1'b1;
                    adj_addr  = root_idx;
                end
            end
            dcd_pkg::ST_SCAN: begin
                if (push_go) begin
                    // Save the parent frame with its resume point, then load the child row.
                    stk_we    = 1'b1;
                    stk_addr  = depth_m1[VW-1:0];
                    stk_wdata = {r_u, NW'(r_w + 1'b1)};
                    adj_rd_en = 1'b1;
                    adj_addr  = w_idx;
                end else if (pop_go) begin
                    stk_addr = depth_m2[VW-1:0];
                end
            end
            dcd_pkg::ST_POP: begin
                adj_rd_en = 1'b1;
                adj_addr  = stk_vertex;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= dcd_pkg::ST_IDLE;
            r_vertex_count <= dcd_pkg::COUNT_RESET;
            r_depth        <= '0;
            r_visited      <= '0;
            r_onpath       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_vertex_count <= i_cfg_data;
            end
            case (r_state)
                dcd_pkg::ST_IDLE: begin
                    if (in_acc && (i_req_type == dcd_pkg::REQ_CHECK)) begin
                        r_visited <= '0;
                        r_onpath  <= '0;
                        r_depth   <= '0;
                    end
                end
                dcd_pkg::ST_ROOT: begin
                    if (root_in && !r_visited[root_idx]) begin
                        r_visited[root_idx] <= 1'b1;
                        r_onpath[root_idx]  <= 1'b1;
                        r_depth             <= (VW+1)'(1);
                    end
                end
                dcd_pkg::ST_SCAN: begin
                    if (pop_go) begin
                        r_onpath[r_u] <= 1'b0;
                        r_depth       <= depth_m1;
                    end else if (push_go) begin
                        r_visited[w_idx] <= 1'b1;
                        r_onpath[w_idx]  <= 1'b1;
                        r_depth          <= r_depth + 1'b1;
                    end
                end
                dcd_pkg::ST_DONE: begin
                    if (out_free) begin
                        r_depth <= '0;
                    end
                end
                default: begin
                end
            endcase
            // Result register parts the search from the output side.
            if ((r_state == dcd_pkg::ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            dcd_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_src  <= src_ext[VW-1:0];
                    r_dst  <= dst_ext[VW-1:0];
                    r_root <= '0;
                end
            end
            dcd_pkg::ST_ROOT: begin
                if (!root_in) begin
                    r_result <= 1'b0;
                end else if (r_visited[root_idx]) begin
                    r_root <= r_root + 1'b1;
                end else begin
                    r_u <= root_idx;
                    r_w <= '0;
                end
            end
            dcd_pkg::ST_SCAN: begin
                if (cyc_hit) begin
                    r_result <= 1'b1;
                end else if (push_go) begin
                    r_u <= w_idx;
                    r_w <= '0;
                end else if (w_in) begin
                    r_w <= r_w + 1'b1;
                end
            end
            dcd_pkg::ST_POP: begin
                r_u <= stk_vertex;
                r_w <= stk_next;
            end
            dcd_pkg::ST_DONE: begin
                if (out_free) begin
                    r_has_cycle <= r_result;
                end
            end
            default: begin
            end
        endcase
    end

    dcd_adj_store #(
        .Depth (MaxVertices)
    ) u_adj (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (adj_rd_en),
        .i_wr_en  (adj_wr_en),
        .i_addr   (adj_addr),
        .i_wr_row (adj_wr_row),
        .o_rd_row (adj_rd_row)
    );

    dcd_stack_store #(
        .Depth (MaxVertices),
        .Width (SW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_addr  (stk_addr),
        .i_wdata (stk_wdata),
        .o_rdata (stk_rdata)
    );

    // Intake is open only while no add or check is in progress.
    assign o_in_stall  = (r_state != dcd_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_has_cycle = r_has_cycle;

    // The stack never holds more frames than there are vertices.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= (VW+1)'(MaxVertices))
        else $error("search depth exceeds vertex store");

    // The vertex being scanned is always on the current path.
    a_top_on_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dcd_pkg::ST_SCAN) |-> r_onpath[r_u])
        else $error("scanned vertex not marked on path");

    // The on-path marks match the stack depth during the scan.
    a_path_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dcd_pkg::ST_SCAN) |-> ($countones(r_onpath) == int'(r_depth)))
        else $error("on-path marks disagree with stack depth");

    // Leaving the done state always presents a result beat.
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == dcd_pkg::ST_DONE) && out_free) |=> r_out_valid)
        else $error("finished check produced no result beat");

endmodule

`default_nettype wire

/* dv/tb_directed_cycle_detect_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for directed_cycle_detect_core: edge adds, cycle checks, vertex counts.
// Depends on dcd_pkg and the core; holds a mirror of the graph that predicts each verdict.

module tb_directed_cycle_detect_core;

    // Run shape. Each random phase reprograms the vertex count, then sends a batch of beats.
    localparam int  NUM_PHASES      = 40;
    localparam int  BEATS_PER_PHASE = 27;
    // A trailing add may still be writing its row after the last verdict; wait for it to finish.
    localparam int  SETTLE_CYCLES   = 8;
    localparam int  DRAIN_CYCLES    = 32;
    // Length of the long receiver hold-off that backs the core up.
    localparam int  HOLD_CYCLES     = 400;
    // Time limit for the run; it allows every beat a full check at 64 vertices
    // plus long stalls, several times over.
    localparam longint LIMIT_NS     = 64'd100_000_000;

    // Mirror of the stored graph. It tracks every accepted beat in order and keeps the
    // verdicts that the core still owes.
    class graph_mirror;
        logic [63:0] adj_rows [64];
        int unsigned live_count;
        bit          verdicts_due [$];
        int          errors;

        function new();
            foreach (adj_rows[i]) adj_rows[i] = '0;
            live_count = dcd_pkg::COUNT_RESET;
            errors     = 0;
        endfunction

        function void set_count(logic [dcd_pkg::COUNT_W-1:0] value);
            live_count = value;
        endfunction

        function int unsigned active_vertices();
            return (live_count > 64) ? 64 : live_count;
        endfunction

        // A graph is acyclic exactly when peeling off vertices with no live successor
        // eventually removes every vertex. A self-loop keeps its vertex alive for good,
        // and edges that touch a vertex outside the active range never count.
        function bit graph_has_cycle();
            logic [63:0] alive;
            int unsigned n;
            bit          changed;
            n       = active_vertices();
            alive   = (n == 64) ? '1 : ((64'd1 << n) - 64'd1);
            changed = 1'b1;
            while (changed) begin
                changed = 1'b0;
                for (int v = 0; v < n; v++) begin
                    if (alive[v] && ((adj_rows[v] & alive) == '0)) begin
                        alive[v] = 1'b0;
                        changed  = 1'b1;
                    end
                end
            end
            return alive != '0;
        endfunction

        function void note_beat(logic req, logic [dcd_pkg::VERTEX_W-1:0] src,
                                logic [dcd_pkg::VERTEX_W-1:0] dst);
            int unsigned n;
            n = active_vertices();
            if (req == dcd_pkg::REQ_ADD) begin
                // Out-of-range endpoints drop the edge; a duplicate simply sets the bit again.
                if (src < n && dst < n) adj_rows[src][dst] = 1'b1;
            end else begin
                verdicts_due = {verdicts_due, graph_has_cycle()};
            end
        endfunction

        function void check_verdict(logic got);
            bit want;
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got has_cycle=%0b",
                         $time, got);
                errors++;
            end else begin
                want = verdicts_due.pop_front();
                if (got !== want) begin
                    $display("%0t: has_cycle mismatch, expected %0b, got %0b",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n      = 1'b0;
    logic                          i_cfg_we     = 1'b0;
    logic [dcd_pkg::COUNT_W-1:0]   i_cfg_data   = '0;
    logic                          i_in_valid   = 1'b0;
    logic                          i_req_type   = dcd_pkg::REQ_ADD;
    logic [dcd_pkg::VERTEX_W-1:0]  i_src_vertex = '0;
    logic [dcd_pkg::VERTEX_W-1:0]  i_dst_vertex = '0;
    logic                          i_out_stall  = 1'b0;
    wire                           o_in_stall;
    wire                           o_out_valid;
    wire                           o_has_cycle;

    graph_mirror mirror = new();

    // Idling controls. The sender's gap rate is only read by the main process; the
    // receiver's stall rate and the hold-off request cross processes, so they change by NBA.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req_cnt   = 0;
    int hold_seen_cnt  = 0;
    int hold_left      = 0;

    directed_cycle_detect_core #(
        .MaxVertices(64)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_src_vertex(i_src_vertex),
        .i_dst_vertex(i_dst_vertex),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_has_cycle (o_has_cycle)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side. Outputs are sampled at the edge before any NBA lands, so the values seen
    // here are the ones the core itself saw. A hold-off request from the main process starts
    // a long stall that this process counts down on its own; otherwise stall is random.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) mirror.check_verdict(o_has_cycle);
        end
        if (hold_seen_cnt != hold_req_cnt) begin
            hold_seen_cnt = hold_req_cnt;
            hold_left     = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offer one request beat and return at the edge that accepts it. Valid only drops when a
    // gap is taken, so back-to-back beats keep it high without a second assignment.
    task automatic send_beat(input logic req, input logic [dcd_pkg::VERTEX_W-1:0] src,
                             input logic [dcd_pkg::VERTEX_W-1:0] dst);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_src_vertex <= src;
        i_dst_vertex <= dst;
        do @(posedge i_clk); while (o_in_stall);
        mirror.note_beat(req, src, dst);
    endtask

    // The register may only change while the core is idle: every verdict is home and any
    // trailing add has had time to finish its row update.
    task automatic write_vertex_count(input logic [dcd_pkg::COUNT_W-1:0] value);
        i_in_valid <= 1'b0;
        while (mirror.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        mirror.set_count(value);
    endtask

    initial begin
        int                           phase;
        int                           k;
        int                           n;
        int                           eff;
        int                           floor_lvl;
        int                           mode;
        bit                           pressure;
        logic [dcd_pkg::VERTEX_W-1:0] src;
        logic [dcd_pkg::VERTEX_W-1:0] dst;
        logic [dcd_pkg::VERTEX_W-1:0] tmp;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, starting at the reset vertex count of 64 with an empty graph.
        send_beat(dcd_pkg::REQ_CHECK, 6'd0, 6'd0);
        send_beat(dcd_pkg::REQ_ADD, 6'd0, 6'd63);
        send_beat(dcd_pkg::REQ_ADD, 6'd0, 6'd63);          // duplicate edge
        send_beat(dcd_pkg::REQ_ADD, 6'd62, 6'd63);
        send_beat(dcd_pkg::REQ_CHECK, 6'd63, 6'd63);
        send_beat(dcd_pkg::REQ_ADD, 6'd63, 6'd63);         // self-loop on the top vertex
        send_beat(dcd_pkg::REQ_CHECK, 6'd0, 6'd0);
        // Shrinking the count hides the self-loop; an add that leaves the range is dropped.
        write_vertex_count(7'd63);
        send_beat(dcd_pkg::REQ_CHECK, 6'd0, 6'd0);
        send_beat(dcd_pkg::REQ_ADD, 6'd63, 6'd0);
        send_beat(dcd_pkg::REQ_CHECK, 6'd0, 6'd0);
        // With no vertices at all, even a self-loop on vertex 0 is ignored.
        write_vertex_count(7'd0);
        send_beat(dcd_pkg::REQ_ADD, 6'd0, 6'd0);
        send_beat(dcd_pkg::REQ_CHECK, 6'd0, 6'd0);
        write_vertex_count(7'd1);
        send_beat(dcd_pkg::REQ_ADD, 6'd1, 6'd0);
        send_beat(dcd_pkg::REQ_ADD, 6'd0, 6'd1);
        send_beat(dcd_pkg::REQ_CHECK, 6'd0, 6'd0);
        // A count above the vertex limit is capped, so the self-loop shows again.
        write_vertex_count(7'd127);
        send_beat(dcd_pkg::REQ_CHECK, 6'd0, 6'd0);
        write_vertex_count(7'd64);
        send_beat(dcd_pkg::REQ_ADD, 6'd40, 6'd63);
        send_beat(dcd_pkg::REQ_CHECK, 6'd0, 6'd0);

        // Random part. The graph is never cleared, so back edges and self-loops are only
        // allowed from vertices at or above a floor that sinks phase by phase. Every cycle
        // then has its highest vertex at or above the floor, and counts picked around the
        // floor give both verdicts throughout the run, with smaller graphs late on.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            floor_lvl = 63 - (phase * 56) / (NUM_PHASES - 1);
            pressure  = (phase % 16 == 7);
            if (pressure) begin
                n = 10;
            end else if ($urandom_range(9) == 0) begin
                case ($urandom_range(4))
                    0: n = 0;
                    1: n = 1;
                    2: n = 64;
                    3: n = 127;
                    default: n = $urandom_range(127, 65);
                endcase
            end else begin
                n = $urandom_range((floor_lvl + 8 > 64) ? 64 : floor_lvl + 8,
                                   (floor_lvl - 8 < 1) ? 1 : floor_lvl - 8);
            end
            eff = (n > 64) ? 64 : n;
            write_vertex_count(n[dcd_pkg::COUNT_W-1:0]);

            // Cycle through no idling, a mostly idle sender, a mostly stalling receiver,
            // and light idling on both sides.
            mode = pressure ? 0 : phase % 4;
            send_idle_pct  = (mode == 1) ? 79 : (mode == 3) ? 16 : 0;
            recv_stall_pct <= (mode == 2) ? 79 : (mode == 3) ? 16 : 0;

            // Under pressure the receiver holds its stall while a check is in flight and the
            // sender keeps offering beats, so the core has to back up its input.
            if (pressure) begin
                hold_req_cnt <= hold_req_cnt + 1;
                send_beat(dcd_pkg::REQ_CHECK, 6'($urandom_range(63)), 6'($urandom_range(63)));
            end

            for (k = 0; k < BEATS_PER_PHASE; k++) begin
                if ($urandom_range(5) == 0) begin
                    send_beat(dcd_pkg::REQ_CHECK, 6'($urandom_range(63)),
                              6'($urandom_range(63)));
                end else begin
                    // Mostly edges inside the active range; now and then any endpoints.
                    if (eff == 0 || $urandom_range(9) == 0) begin
                        src = 6'($urandom_range(63));
                        dst = 6'($urandom_range(63));
                    end else begin
                        src = 6'($urandom_range(eff - 1));
                        dst = 6'($urandom_range(eff - 1));
                    end
                    // Below the floor, turn a back edge or self-loop into a forward edge.
                    if (src >= dst && src < floor_lvl) begin
                        if (src == dst) dst = src ^ 6'd1;
                        if (src > dst) begin
                            tmp = src;
                            src = dst;
                            dst = tmp;
                        end
                    end
                    send_beat(dcd_pkg::REQ_ADD, src, dst);
                end
            end
        end

        // Drain: let every owed verdict arrive, then watch a while for stray result beats.
        i_in_valid <= 1'b0;
        while (mirror.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mirror.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog for a core that hangs or never answers.
    initial begin
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
